[rtl/ctok_pkg.sv]
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, token codes and keyword tables for the C subset tokenizer.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int POS_W  = 16;
  localparam int LINE_W = 16;
  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam int NUM_KW = 10;
  localparam logic [NUM_KW-1:0] KW_ALL = {NUM_KW{1'b1}};

  // token kinds
  localparam logic [5:0] K_IDENT  = 6'd10;
  localparam logic [5:0] K_INT    = 6'd11;
  localparam logic [5:0] K_FLOAT  = 6'd12;
  localparam logic [5:0] K_STRING = 6'd13;
  localparam logic [5:0] K_CHAR   = 6'd14;
  localparam logic [5:0] K_PLUS   = 6'd15;
  localparam logic [5:0] K_MINUS  = 6'd16;
  localparam logic [5:0] K_STAR   = 6'd17;
  localparam logic [5:0] K_SLASH  = 6'd18;
  localparam logic [5:0] K_PCT    = 6'd19;
  localparam logic [5:0] K_ASSIGN = 6'd20;
  localparam logic [5:0] K_NOT    = 6'd22;
  localparam logic [5:0] K_LT     = 6'd24;
  localparam logic [5:0] K_GT     = 6'd26;
  localparam logic [5:0] K_ANDAND = 6'd28;
  localparam logic [5:0] K_OROR   = 6'd29;
  localparam logic [5:0] K_LPAREN = 6'd30;
  localparam logic [5:0] K_RPAREN = 6'd31;
  localparam logic [5:0] K_LBRACE = 6'd32;
  localparam logic [5:0] K_RBRACE = 6'd33;
  localparam logic [5:0] K_SEMI   = 6'd34;
  localparam logic [5:0] K_COMMA  = 6'd35;
  localparam logic [5:0] K_EOF    = 6'd36;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_AMP     = 3'd1;
  localparam logic [2:0] E_BAR     = 3'd2;
  localparam logic [2:0] E_BADCHAR = 3'd3;
  localparam logic [2:0] E_STRING  = 3'd4;
  localparam logic [2:0] E_CHARLIT = 3'd5;

  // keyword text, padded with zero bytes
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd6, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6
  };

  typedef enum logic [3:0] {
    S_IDLE, S_IDENT, S_INT, S_FLOAT, S_STRING, S_CHARV, S_CHARC,
    S_PEQ, S_PNOT, S_PLT, S_PGT, S_PAMP, S_PBAR, S_DISCARD
  } scan_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] token_line;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  char_value;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    scan_state_t         st;
    logic [POS_W-1:0]    offset;
    logic [LINE_W-1:0]   line;
    logic [POS_W-1:0]    lex_start;
    logic [POS_W-1:0]    lex_len;
    logic [NUM_KW-1:0]   kw_cand;
    logic [7:0]          lit_char;
  } scan_regs_t;

  localparam scan_regs_t SCAN_RESET = '{
    st: S_IDLE, offset: '0, line: LINE_W'(1), lex_start: '0,
    lex_len: '0, kw_cand: KW_ALL, lit_char: '0
  };

endpackage

[rtl/ctok_scan.sv]
// ----------------------------------------------------------------------------
// ctok_scan
// Next-state and token logic for one source byte and the end-of-source flush.
// ----------------------------------------------------------------------------
module ctok_scan import ctok_pkg::*; (
  input  scan_regs_t cur,
  input  in_item_t   item,
  output scan_regs_t nxt,
  output token_t     res [3],
  output logic [1:0] count
);

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] x);
    return (x == POS_MAX) ? x : x + POS_W'(1);
  endfunction

  function automatic token_t make_tok(input logic [5:0] kind, input logic [2:0] err,
                                      input logic [LINE_W-1:0] line,
                                      input logic [POS_W-1:0] start,
                                      input logic [POS_W-1:0] len,
                                      input logic [7:0] ch);
    token_t t;
    t.token_kind   = kind;
    t.error_code   = err;
    t.token_line   = line[15:0];
    t.token_start  = start[15:0];
    t.token_length = len[15:0];
    t.char_value   = ch;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                              input logic [POS_W-1:0] pos,
                                              input logic [7:0] c);
    logic [NUM_KW-1:0] r;
    r = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      if (pos >= POS_W'(KW_LEN[k]) || KW_TEXT[k][pos[2:0]] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] word_kind(input logic [NUM_KW-1:0] cand,
                                           input logic [POS_W-1:0] len);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && len == POS_W'(KW_LEN[k])) kind = 6'(k);
    end
    return kind;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  scan_regs_t  v;
  logic [7:0]  c;
  logic        redo;
  logic [1:0]  n;
  logic [5:0]  one;
  logic [5:0]  base;

  always_comb begin
    v    = cur;
    c    = item.char_code;
    redo = 1'b0;
    n    = 2'd0;
    one  = '0;
    base = '0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    // byte scan for the current state
    if (item.has_char) begin
      case (v.st)
        S_IDLE: redo = 1'b1;
        S_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            v.kw_cand = narrow(v.kw_cand, v.lex_len, c);
            v.lex_len = pos_inc(v.lex_len);
          end else begin
            res[n] = make_tok(word_kind(v.kw_cand, v.lex_len), E_NONE, v.line,
                              v.lex_start, v.lex_len, 8'h00);
            n = n + 2'd1;
            v.st = S_IDLE;
            redo = 1'b1;
          end
        end
        S_INT, S_FLOAT: begin
          if (is_digit(c) || (v.st == S_INT && c == ".")) begin
            if (c == ".") v.st = S_FLOAT;
            v.lex_len = pos_inc(v.lex_len);
          end else begin
            res[n] = make_tok((v.st == S_INT) ? K_INT : K_FLOAT, E_NONE, v.line,
                              v.lex_start, v.lex_len, 8'h00);
            n = n + 2'd1;
            v.st = S_IDLE;
            redo = 1'b1;
          end
        end
        S_STRING: begin
          if (c == "\"") begin
            res[n] = make_tok(K_STRING, E_NONE, v.line, v.lex_start, v.lex_len, 8'h00);
            n = n + 2'd1;
            v.st = S_IDLE;
          end else begin
            if (c == 8'h0a && v.line != LINE_MAX) v.line = v.line + LINE_W'(1);
            v.lex_len = pos_inc(v.lex_len);
          end
        end
        S_CHARV: begin
          v.lit_char  = c;
          v.lex_start = v.offset;
          v.st        = S_CHARC;
        end
        S_CHARC: begin
          if (c == "'") begin
            res[n] = make_tok(K_CHAR, E_NONE, v.line, v.lex_start, POS_W'(1), v.lit_char);
            v.st = S_IDLE;
          end else begin
            res[n] = make_tok(6'd0, E_CHARLIT, v.line, v.offset, '0, 8'h00);
            v.st = S_DISCARD;
          end
          n = n + 2'd1;
        end
        S_PAMP, S_PBAR: begin
          if (c == ((v.st == S_PAMP) ? "&" : "|")) begin
            res[n] = make_tok((v.st == S_PAMP) ? K_ANDAND : K_OROR, E_NONE, v.line,
                              v.lex_start, POS_W'(2), 8'h00);
            v.st = S_IDLE;
          end else begin
            res[n] = make_tok(6'd0, (v.st == S_PAMP) ? E_AMP : E_BAR, v.line,
                              v.offset, '0, 8'h00);
            v.st = S_DISCARD;
          end
          n = n + 2'd1;
        end
        S_PEQ, S_PNOT, S_PLT, S_PGT: begin
          case (v.st)
            S_PEQ:   base = K_ASSIGN;
            S_PNOT:  base = K_NOT;
            S_PLT:   base = K_LT;
            default: base = K_GT;
          endcase
          if (c == "=") begin
            res[n] = make_tok(base + 6'd1, E_NONE, v.line, v.lex_start, POS_W'(2), 8'h00);
          end else begin
            res[n] = make_tok(base, E_NONE, v.line, v.lex_start, POS_W'(1), 8'h00);
            redo = 1'b1;
          end
          n = n + 2'd1;
          v.st = S_IDLE;
        end
        default: ;
      endcase

      // fresh scan from the idle state
      if (redo) begin
        one = '0;
        case (c)
          " ", 8'h09, 8'h0d: ;
          8'h0a: if (v.line != LINE_MAX) v.line = v.line + LINE_W'(1);
          "+": one = K_PLUS;
          "-": one = K_MINUS;
          "*": one = K_STAR;
          "/": one = K_SLASH;
          "%": one = K_PCT;
          "(": one = K_LPAREN;
          ")": one = K_RPAREN;
          "{": one = K_LBRACE;
          "}": one = K_RBRACE;
          ";": one = K_SEMI;
          ",": one = K_COMMA;
          "=", "!", "<", ">", "&", "|": begin
            case (c)
              "=":     v.st = S_PEQ;
              "!":     v.st = S_PNOT;
              "<":     v.st = S_PLT;
              ">":     v.st = S_PGT;
              "&":     v.st = S_PAMP;
              default: v.st = S_PBAR;
            endcase
            v.lex_start = v.offset;
            v.lex_len   = POS_W'(1);
          end
          "\"": begin
            v.st        = S_STRING;
            v.lex_start = pos_inc(v.offset);
            v.lex_len   = '0;
          end
          "'": v.st = S_CHARV;
          default: begin
            if (is_digit(c)) begin
              v.st        = S_INT;
              v.lex_start = v.offset;
              v.lex_len   = POS_W'(1);
            end else if (is_alpha(c) || c == "_") begin
              v.st        = S_IDENT;
              v.lex_start = v.offset;
              v.lex_len   = POS_W'(1);
              v.kw_cand   = narrow(KW_ALL, '0, c);
            end else begin
              res[n] = make_tok(6'd0, E_BADCHAR, v.line, v.offset, '0, 8'h00);
              n = n + 2'd1;
              v.st = S_DISCARD;
            end
          end
        endcase
        if (one != '0) begin
          res[n] = make_tok(one, E_NONE, v.line, v.offset, POS_W'(1), 8'h00);
          n = n + 2'd1;
        end
      end
      v.offset = pos_inc(v.offset);
    end

    // end of source: flush pending token, then end-of-file unless failed
    if (item.end_of_source) begin
      case (v.st)
        S_IDLE: ;
        S_IDENT: begin
          res[n] = make_tok(word_kind(v.kw_cand, v.lex_len), E_NONE, v.line,
                            v.lex_start, v.lex_len, 8'h00);
          n = n + 2'd1;
        end
        S_INT, S_FLOAT: begin
          res[n] = make_tok((v.st == S_INT) ? K_INT : K_FLOAT, E_NONE, v.line,
                            v.lex_start, v.lex_len, 8'h00);
          n = n + 2'd1;
        end
        S_STRING: begin
          res[n] = make_tok(6'd0, E_STRING, v.line, v.offset, '0, 8'h00);
          n = n + 2'd1;
        end
        S_CHARV, S_CHARC: begin
          res[n] = make_tok(6'd0, E_CHARLIT, v.line, v.offset, '0, 8'h00);
          n = n + 2'd1;
        end
        S_PAMP: begin
          res[n] = make_tok(6'd0, E_AMP, v.line, v.offset, '0, 8'h00);
          n = n + 2'd1;
        end
        S_PBAR: begin
          res[n] = make_tok(6'd0, E_BAR, v.line, v.offset, '0, 8'h00);
          n = n + 2'd1;
        end
        S_PEQ: begin
          res[n] = make_tok(K_ASSIGN, E_NONE, v.line, v.lex_start, POS_W'(1), 8'h00);
          n = n + 2'd1;
        end
        S_PNOT: begin
          res[n] = make_tok(K_NOT, E_NONE, v.line, v.lex_start, POS_W'(1), 8'h00);
          n = n + 2'd1;
        end
        S_PLT: begin
          res[n] = make_tok(K_LT, E_NONE, v.line, v.lex_start, POS_W'(1), 8'h00);
          n = n + 2'd1;
        end
        S_PGT: begin
          res[n] = make_tok(K_GT, E_NONE, v.line, v.lex_start, POS_W'(1), 8'h00);
          n = n + 2'd1;
        end
        default: ;
      endcase
      if (!(v.st == S_DISCARD || v.st == S_STRING || v.st == S_CHARV ||
            v.st == S_CHARC || v.st == S_PAMP || v.st == S_PBAR)) begin
        res[n] = make_tok(K_EOF, E_NONE, v.line, v.offset, '0, 8'h00);
        n = n + 2'd1;
      end
      v = SCAN_RESET;
    end

    // mark the final result of this transaction
    for (int i = 0; i < 3; i++) res[i].last_of_run = (2'(i) == n - 2'd1) && (n != 2'd0);
    nxt   = v;
    count = n;
  end

endmodule

[rtl/c_subset_tokenizer.sv]
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming lexer for a small C-like language, one source byte per transaction.
// ----------------------------------------------------------------------------
// Output: the first token of a transaction is valid the cycle after acceptance.
// Throughput: one byte per cycle without out_stall; up to 3 tokens per byte
// drain one per cycle, and the input is held until the last one is taken.
// Reset: synchronous; scanner state returns to idle, line 1, offset 0, and the
// result buffer empties.
module c_subset_tokenizer import ctok_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output token_t   out_data
);

  scan_regs_t regs;
  scan_regs_t regs_next;
  token_t     res [3];
  logic [1:0] res_count;
  token_t     rbuf [3];
  logic [1:0] cnt;
  logic [1:0] rd;
  logic       in_take;
  logic       out_take;

  ctok_scan u_scan (
    .cur   (regs),
    .item  (in_data),
    .nxt   (regs_next),
    .res   (res),
    .count (res_count)
  );

  // buffer drain and refill control
  assign out_valid = (rd != cnt);
  assign out_data  = rbuf[rd];
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = !((rd == cnt) || ((rd + 2'd1) == cnt && !out_stall));
  assign in_take   = in_valid && !in_stall;

  // scanner state and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= SCAN_RESET;
      cnt  <= 2'd0;
      rd   <= 2'd0;
    end else if (in_take) begin
      regs <= regs_next;
      rbuf <= res;
      cnt  <= res_count;
      rd   <= 2'd0;
    end else if (out_take) begin
      rd <= rd + 2'd1;
    end
  end

endmodule
